>>> rtl/cdq_pkg.sv
// Shared types and codes for the two-class age-ordered queue.
package cdq_pkg;

	localparam int unsigned ID_BITS = 16;

	// Operation codes.
	localparam logic [1:0] OP_PUSH    = 2'd0;
	localparam logic [1:0] OP_POP_ANY = 2'd1;
	localparam logic [1:0] OP_POP_DOG = 2'd2;
	localparam logic [1:0] OP_POP_CAT = 2'd3;

	// Class codes on the request side.
	localparam logic [1:0] PET_CAT = 2'd0;
	localparam logic [1:0] PET_DOG = 2'd1;

	// Class bit on the response side.
	localparam logic OUT_CAT = 1'b0;
	localparam logic OUT_DOG = 1'b1;

	// Status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	typedef struct packed {
		logic push;
		logic pop;
	} lane_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic one;
	} lane_stat_t;

endpackage

>>> rtl/cdq_if.sv
// Request and response channel interfaces of the two-class age-ordered queue.
interface cdq_req_if;
	import cdq_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic [1:0]         pet_class;
	logic [ID_BITS-1:0] pet_id;

	modport source (output valid, output opcode, output pet_class, output pet_id, input ready);
	modport sink   (input valid, input opcode, input pet_class, input pet_id, output ready);
endinterface

interface cdq_rsp_if;
	import cdq_pkg::*;
	logic               valid;
	logic               ready;
	logic [ID_BITS-1:0] out_pet_id;
	logic               out_pet_class;
	logic [1:0]         status;
	logic               cat_empty;
	logic               dog_empty;
	logic               all_empty;

	modport source (output valid, output out_pet_id, output out_pet_class, output status,
		output cat_empty, output dog_empty, output all_empty, input ready);
	modport sink   (input valid, input out_pet_id, input out_pet_class, input status,
		input cat_empty, input dog_empty, input all_empty, output ready);
endinterface

>>> rtl/cdq_lane.sv
// One class FIFO: entry array with sequence tags, head pointer and fill count.
module cdq_lane #(
	parameter int unsigned DEPTH    = 16,
	parameter int unsigned TAG_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cdq_pkg::lane_ctl_t          ctl,
	input  logic [cdq_pkg::ID_BITS-1:0] wr_id,
	input  logic [TAG_BITS-1:0]         wr_tag,
	output cdq_pkg::lane_stat_t         stat,
	output logic [cdq_pkg::ID_BITS-1:0] head_id,
	output logic [TAG_BITS-1:0]         head_tag
);
	import cdq_pkg::*;

	localparam int unsigned AW      = $clog2(DEPTH);
	localparam logic [AW:0] DEPTH_C = (AW+1)'(DEPTH);
	localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);

	logic [ID_BITS-1:0]  id_mem  [DEPTH];
	logic [TAG_BITS-1:0] tag_mem [DEPTH];
	logic [AW-1:0]       head_q;
	logic [AW:0]         fill_q;
	logic [AW:0]         tail_sum;
	logic [AW:0]         tail_wrap;
	logic [AW-1:0]       wr_addr;
	logic [AW-1:0]       head_nxt;

	// The tail is head plus fill, folded back once into the ring.
	assign tail_sum  = {1'b0, head_q} + fill_q;
	assign tail_wrap = (tail_sum >= DEPTH_C) ? tail_sum - DEPTH_C : tail_sum;
	assign wr_addr   = tail_wrap[AW-1:0];
	assign head_nxt  = (head_q == LAST) ? '0 : head_q + 1'b1;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			id_mem[wr_addr]  <= wr_id;
			tag_mem[wr_addr] <= wr_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (ctl.push) begin
			fill_q <= fill_q + 1'b1;
		end else if (ctl.pop) begin
			head_q <= head_nxt;
			fill_q <= fill_q - 1'b1;
		end
	end

	assign head_id    = id_mem[head_q];
	assign head_tag   = tag_mem[head_q];
	assign stat.empty = (fill_q == '0);
	assign stat.full  = (fill_q == DEPTH_C);
	assign stat.one   = (fill_q == (AW+1)'(1));

endmodule

>>> rtl/two_class_age_ordered_queue_unit.sv
// Top level of the two-class age-ordered queue with input and result registers.
//
// The unit takes one word per cycle unless the response side stalls, and returns
// exactly one response word for every request. A request first lands in an input
// register; the decision logic then reads both FIFO heads straight from their register
// arrays and, once the response register is free or being read, updates pointers,
// fill counts and the sequence counter and loads the response register. Because the
// response register separates the two sides, a new request can enter an empty input
// register while an earlier response still waits; the sustained rate of one word per
// cycle while responses are taken is set only by the single decision stage. Each
// queue holds QUEUE_DEPTH entries of identifier plus a SEQ_BITS-bit age tag; pop-any
// compares the two head tags modulo 2^SEQ_BITS and gives the dog head on equal tags.
module two_class_age_ordered_queue_unit #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned SEQ_BITS    = 16
) (
	input logic      clk,
	input logic      arst_n,
	cdq_req_if.sink  req,
	cdq_rsp_if.source rsp
);
	import cdq_pkg::*;

	// Input register.
	logic               v_s1;
	logic [1:0]         op_s1;
	logic [1:0]         cls_s1;
	logic [ID_BITS-1:0] id_s1;

	logic               advance;
	logic [SEQ_BITS-1:0] seq_q;

	lane_ctl_t           cat_ctl, dog_ctl, cat_ctl_g, dog_ctl_g;
	lane_stat_t          cat_stat, dog_stat;
	logic [ID_BITS-1:0]  cat_head_id, dog_head_id;
	logic [SEQ_BITS-1:0] cat_head_tag, dog_head_tag;
	logic [SEQ_BITS-1:0] tag_diff;
	logic                cat_older;

	logic               seq_adv;
	logic               have;
	logic               take_cat;
	logic [ID_BITS-1:0] res_id;
	logic               res_cls;
	logic [1:0]         res_status;
	logic               cat_empty_nxt, dog_empty_nxt;

	// Response register.
	logic               rsp_v_q;
	logic [ID_BITS-1:0] rsp_id_q;
	logic               rsp_cls_q;
	logic [1:0]         rsp_status_q;
	logic               rsp_cat_empty_q, rsp_dog_empty_q;

	assign advance   = v_s1 && (!rsp_v_q || rsp.ready);
	assign req.ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1  <= req.opcode;
			cls_s1 <= req.pet_class;
			id_s1  <= req.pet_id;
		end
	end

	cdq_lane #(.DEPTH(QUEUE_DEPTH), .TAG_BITS(SEQ_BITS)) u_cat (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (cat_ctl_g),
		.wr_id    (id_s1),
		.wr_tag   (seq_q),
		.stat     (cat_stat),
		.head_id  (cat_head_id),
		.head_tag (cat_head_tag)
	);

	cdq_lane #(.DEPTH(QUEUE_DEPTH), .TAG_BITS(SEQ_BITS)) u_dog (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (dog_ctl_g),
		.wr_id    (id_s1),
		.wr_tag   (seq_q),
		.stat     (dog_stat),
		.head_id  (dog_head_id),
		.head_tag (dog_head_tag)
	);

	// The cat head is older when the dog tag lies strictly ahead within half the ring.
	assign tag_diff  = dog_head_tag - cat_head_tag;
	assign cat_older = (tag_diff != '0) && !tag_diff[SEQ_BITS-1];

	always_comb begin
		cat_ctl    = '0;
		dog_ctl    = '0;
		seq_adv    = 1'b0;
		have       = 1'b0;
		take_cat   = 1'b0;
		res_id     = '0;
		res_cls    = OUT_CAT;
		res_status = ST_OK;
		unique case (op_s1)
			OP_PUSH: begin
				if (cls_s1 == PET_CAT) begin
					if (cat_stat.full) begin
						res_status = ST_FULL;
					end else begin
						cat_ctl.push = 1'b1;
						seq_adv      = 1'b1;
					end
				end else if (cls_s1 == PET_DOG) begin
					if (dog_stat.full) begin
						res_status = ST_FULL;
					end else begin
						dog_ctl.push = 1'b1;
						seq_adv      = 1'b1;
					end
				end else begin
					res_status = ST_UNKNOWN;
					seq_adv    = 1'b1;
				end
			end
			OP_POP_ANY: begin
				have = !cat_stat.empty || !dog_stat.empty;
				if (dog_stat.empty) begin
					take_cat = 1'b1;
				end else if (cat_stat.empty) begin
					take_cat = 1'b0;
				end else begin
					take_cat = cat_older;
				end
			end
			OP_POP_DOG: begin
				have     = !dog_stat.empty;
				take_cat = 1'b0;
			end
			OP_POP_CAT: begin
				have     = !cat_stat.empty;
				take_cat = 1'b1;
			end
			default: begin
				have = 1'b0;
			end
		endcase

		if (op_s1 != OP_PUSH) begin
			if (!have) begin
				res_status = ST_EMPTY;
			end else if (take_cat) begin
				cat_ctl.pop = 1'b1;
				res_id      = cat_head_id;
				res_cls     = OUT_CAT;
			end else begin
				dog_ctl.pop = 1'b1;
				res_id      = dog_head_id;
				res_cls     = OUT_DOG;
			end
		end
	end

	assign cat_ctl_g = advance ? cat_ctl : '0;
	assign dog_ctl_g = advance ? dog_ctl : '0;

	assign cat_empty_nxt = cat_ctl.push ? 1'b0 : (cat_ctl.pop ? cat_stat.one : cat_stat.empty);
	assign dog_empty_nxt = dog_ctl.push ? 1'b0 : (dog_ctl.pop ? dog_stat.one : dog_stat.empty);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= '0;
		end else if (advance && seq_adv) begin
			seq_q <= seq_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (advance) begin
			rsp_v_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_id_q        <= res_id;
			rsp_cls_q       <= res_cls;
			rsp_status_q    <= res_status;
			rsp_cat_empty_q <= cat_empty_nxt;
			rsp_dog_empty_q <= dog_empty_nxt;
		end
	end

	assign rsp.valid         = rsp_v_q;
	assign rsp.out_pet_id    = rsp_id_q;
	assign rsp.out_pet_class = rsp_cls_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.cat_empty     = rsp_cat_empty_q;
	assign rsp.dog_empty     = rsp_dog_empty_q;
	assign rsp.all_empty     = rsp_cat_empty_q && rsp_dog_empty_q;

endmodule

>>> rtl/cdq_checker.sv
// Port-level checks for the two-class age-ordered queue and their binding.
module cdq_port_checks (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [cdq_pkg::ID_BITS-1:0] out_pet_id,
	input logic                        out_pet_class,
	input logic [1:0]                  status,
	input logic                        cat_empty,
	input logic                        dog_empty,
	input logic                        all_empty
);
	import cdq_pkg::*;

	// The combined flag must agree with the two class flags.
	a_all_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (all_empty == (cat_empty && dog_empty)))
		else $error("all_empty disagrees with the class empty flags");

	// A word with a status other than OK carries no identity.
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != ST_OK) |-> (out_pet_id == '0 && out_pet_class == OUT_CAT))
		else $error("non-ok response carries a pet identity");

	// A failed pop means the queue it targeted was already empty, so at least one is empty.
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_EMPTY) |-> (cat_empty || dog_empty))
		else $error("pop reported empty while both queues hold entries");

	// A stalled response word stays in place.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(out_pet_id) && $stable(status)))
		else $error("stalled response word changed");

endmodule

bind two_class_age_ordered_queue_unit cdq_port_checks u_cdq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.out_pet_id    (rsp.out_pet_id),
	.out_pet_class (rsp.out_pet_class),
	.status        (rsp.status),
	.cat_empty     (rsp.cat_empty),
	.dog_empty     (rsp.dog_empty),
	.all_empty     (rsp.all_empty)
);
